FILE: sv/sdt_pkg.sv
package sdt_pkg;

	// Field widths and fixed packet geometry.
	localparam int MAX_NAME_LEN_DEF = 64;
	localparam int PACKET_LEN       = 188;
	localparam int LEN_W            = 7;
	localparam int PC_W             = 6;
	localparam int SECT_FIXED       = 21;
	localparam int LOOP_FIXED       = 5;
	localparam int DESC_FIXED       = 3;
	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Operation codes carried on the input tuser.
	typedef enum logic [1:0] {
		OP_WR_PROV = 2'd0,
		OP_WR_NAME = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_TSID    = 3'd0,
		REG_ONID    = 3'd1,
		REG_SID     = 3'd2,
		REG_PLEN    = 3'd3,
		REG_NLEN    = 3'd4,
		REG_VERSION = 3'd5,
		REG_RUN     = 3'd6,
		REG_KIND    = 3'd7
	} reg_idx_t;

	// Byte sources selected by the microcode.
	typedef enum logic [4:0] {
		SRC_CONST,
		SRC_SLEN_HI,
		SRC_SLEN_LO,
		SRC_TSID_HI,
		SRC_TSID_LO,
		SRC_VER,
		SRC_ONID_HI,
		SRC_ONID_LO,
		SRC_SID_HI,
		SRC_SID_LO,
		SRC_LOOP_HI,
		SRC_LOOP_LO,
		SRC_DLEN,
		SRC_KIND,
		SRC_PLEN,
		SRC_PROV,
		SRC_NLEN,
		SRC_NAME,
		SRC_CRC3,
		SRC_CRC2,
		SRC_CRC1,
		SRC_CRC0
	} src_t;

	// Sequencer operations.
	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_SKIP_EMPTY,
		SEQ_LOOP,
		SEQ_HOLD
	} seq_op_t;

	typedef enum logic {
		LEN_PROV,
		LEN_NAME
	} len_sel_t;

	// One microcode word.
	typedef struct packed {
		src_t             src;
		logic [7:0]       konst;
		logic             crc_en;
		seq_op_t          seq;
		len_sel_t         len_sel;
		logic [PC_W-1:0]  target;
	} ucode_t;

	// Control handed from the sequencer to the datapath.
	typedef struct packed {
		src_t       src;
		logic [7:0] konst;
		logic       crc_en;
		logic       last;
	} seq_ctrl_t;

	// Configuration as seen by the datapath; lengths already saturated.
	typedef struct packed {
		logic [15:0]      tsid;
		logic [15:0]      onid;
		logic [15:0]      sid;
		logic [LEN_W-1:0] plen;
		logic [LEN_W-1:0] nlen;
		logic [4:0]       version;
		logic [2:0]       run;
		logic [7:0]       kind;
	} cfg_t;

	// Program entry points used as jump targets.
	localparam logic [PC_W-1:0] ST_NLEN = PC_W'(26);
	localparam logic [PC_W-1:0] ST_CRC  = PC_W'(28);

	function automatic ucode_t uw(src_t src, logic [7:0] konst, logic crc_en,
		seq_op_t seq, len_sel_t len_sel, logic [PC_W-1:0] target);
		ucode_t w;
		w.src     = src;
		w.konst   = konst;
		w.crc_en  = crc_en;
		w.seq     = seq;
		w.len_sel = len_sel;
		w.target  = target;
		return w;
	endfunction

	// Microprogram: one word per fixed byte, with looping words over the name bytes
	// and a final step that holds on padding until the packet closes.
	function automatic ucode_t rom_word(logic [PC_W-1:0] pc);
		ucode_t w;
		w = uw(SRC_CONST, 8'hFF, 1'b0, SEQ_HOLD, LEN_PROV, '0);
		unique case (pc)
			6'd0:  w = uw(SRC_CONST,   8'h47, 1'b0, SEQ_NEXT, LEN_PROV, '0);
			6'd1:  w = uw(SRC_CONST,   8'h40, 1'b0, SEQ_NEXT, LEN_PROV, '0);
			6'd2:  w = uw(SRC_CONST,   8'h11, 1'b0, SEQ_NEXT, LEN_PROV, '0);
			6'd3:  w = uw(SRC_CONST,   8'h10, 1'b0, SEQ_NEXT, LEN_PROV, '0);
			6'd4:  w = uw(SRC_CONST,   8'h00, 1'b0, SEQ_NEXT, LEN_PROV, '0);
			6'd5:  w = uw(SRC_CONST,   8'h42, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd6:  w = uw(SRC_SLEN_HI, 8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd7:  w = uw(SRC_SLEN_LO, 8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd8:  w = uw(SRC_TSID_HI, 8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd9:  w = uw(SRC_TSID_LO, 8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd10: w = uw(SRC_VER,     8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd11: w = uw(SRC_CONST,   8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd12: w = uw(SRC_CONST,   8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd13: w = uw(SRC_ONID_HI, 8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd14: w = uw(SRC_ONID_LO, 8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd15: w = uw(SRC_CONST,   8'hFF, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd16: w = uw(SRC_SID_HI,  8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd17: w = uw(SRC_SID_LO,  8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd18: w = uw(SRC_CONST,   8'hFF, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd19: w = uw(SRC_LOOP_HI, 8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd20: w = uw(SRC_LOOP_LO, 8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd21: w = uw(SRC_CONST,   8'h48, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd22: w = uw(SRC_DLEN,    8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd23: w = uw(SRC_KIND,    8'h00, 1'b1, SEQ_NEXT, LEN_PROV, '0);
			6'd24: w = uw(SRC_PLEN,    8'h00, 1'b1, SEQ_SKIP_EMPTY, LEN_PROV, ST_NLEN);
			6'd25: w = uw(SRC_PROV,    8'h00, 1'b1, SEQ_LOOP, LEN_PROV, '0);
			6'd26: w = uw(SRC_NLEN,    8'h00, 1'b1, SEQ_SKIP_EMPTY, LEN_NAME, ST_CRC);
			6'd27: w = uw(SRC_NAME,    8'h00, 1'b1, SEQ_LOOP, LEN_NAME, '0);
			6'd28: w = uw(SRC_CRC3,    8'h00, 1'b0, SEQ_NEXT, LEN_PROV, '0);
			6'd29: w = uw(SRC_CRC2,    8'h00, 1'b0, SEQ_NEXT, LEN_PROV, '0);
			6'd30: w = uw(SRC_CRC1,    8'h00, 1'b0, SEQ_NEXT, LEN_PROV, '0);
			6'd31: w = uw(SRC_CRC0,    8'h00, 1'b0, SEQ_NEXT, LEN_PROV, '0);
			default: w = uw(SRC_CONST, 8'hFF, 1'b0, SEQ_HOLD, LEN_PROV, '0);
		endcase
		return w;
	endfunction

	// CRC-32/MPEG-2 over one byte, MSB first.
	function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] b);
		logic [31:0] c;
		logic        fb;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			fb = c[31] ^ b[i];
			c  = {c[30:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/sdt_apb_regs.sv
module sdt_apb_regs
	import sdt_pkg::*;
#(
	parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);

	logic [15:0]      tsid_q;
	logic [15:0]      onid_q;
	logic [15:0]      sid_q;
	logic [LEN_W-1:0] plen_q;
	logic [LEN_W-1:0] nlen_q;
	logic [4:0]       version_q;
	logic [2:0]       run_q;
	logic [7:0]       kind_q;
	reg_idx_t         idx;
	logic             wr_en;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NAME_LEN);

	assign idx   = reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite;

	// Register writes on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsid_q    <= '0;
			onid_q    <= '0;
			sid_q     <= '0;
			plen_q    <= '0;
			nlen_q    <= '0;
			version_q <= 5'd2;
			run_q     <= 3'd4;
			kind_q    <= 8'd1;
		end else if (wr_en) begin
			unique case (idx)
				REG_TSID:    tsid_q    <= pwdata[15:0];
				REG_ONID:    onid_q    <= pwdata[15:0];
				REG_SID:     sid_q     <= pwdata[15:0];
				REG_PLEN:    plen_q    <= pwdata[LEN_W-1:0];
				REG_NLEN:    nlen_q    <= pwdata[LEN_W-1:0];
				REG_VERSION: version_q <= pwdata[4:0];
				REG_RUN:     run_q     <= pwdata[2:0];
				REG_KIND:    kind_q    <= pwdata[7:0];
				default:     tsid_q    <= tsid_q;
			endcase
		end
	end

	// Read mux returns the raw register values.
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_TSID:    prdata = {16'd0, tsid_q};
			REG_ONID:    prdata = {16'd0, onid_q};
			REG_SID:     prdata = {16'd0, sid_q};
			REG_PLEN:    prdata = {25'd0, plen_q};
			REG_NLEN:    prdata = {25'd0, nlen_q};
			REG_VERSION: prdata = {27'd0, version_q};
			REG_RUN:     prdata = {29'd0, run_q};
			REG_KIND:    prdata = {24'd0, kind_q};
			default:     prdata = '0;
		endcase
	end

	// Name lengths above the store depth saturate to the depth.
	always_comb begin
		cfg.tsid    = tsid_q;
		cfg.onid    = onid_q;
		cfg.sid     = sid_q;
		cfg.plen    = (plen_q > LEN_MAX) ? LEN_MAX : plen_q;
		cfg.nlen    = (nlen_q > LEN_MAX) ? LEN_MAX : nlen_q;
		cfg.version = version_q;
		cfg.run     = run_q;
		cfg.kind    = kind_q;
	end

endmodule

FILE: sv/sdt_sequencer.sv
module sdt_sequencer
	import sdt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [LEN_W-1:0] plen,
	input  logic [LEN_W-1:0] nlen,
	output seq_ctrl_t        ctrl,
	output logic [LEN_W-1:0] cnt
);

	logic [PC_W-1:0]  pc_q;
	logic [LEN_W-1:0] cnt_q;
	logic [7:0]       pos_q;
	logic [PC_W-1:0]  pc_d;
	logic [LEN_W-1:0] cnt_d;
	logic [7:0]       pos_d;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] cnt_inc;
	logic             last;
	ucode_t           uc;

	assign uc      = rom_word(pc_q);
	assign last    = (pos_q == 8'(PACKET_LEN - 1));
	assign len     = (uc.len_sel == LEN_NAME) ? nlen : plen;
	assign cnt_inc = cnt_q + LEN_W'(1);

	assign ctrl.src    = uc.src;
	assign ctrl.konst  = uc.konst;
	assign ctrl.crc_en = uc.crc_en;
	assign ctrl.last   = last;
	assign cnt         = cnt_q;

	// Next step, loop count and byte position.
	always_comb begin
		pc_d  = pc_q;
		cnt_d = cnt_q;
		pos_d = pos_q + 8'd1;
		unique case (uc.seq)
			SEQ_NEXT: pc_d = pc_q + PC_W'(1);
			SEQ_SKIP_EMPTY: begin
				cnt_d = '0;
				pc_d  = (len == '0) ? uc.target : pc_q + PC_W'(1);
			end
			SEQ_LOOP: begin
				cnt_d = cnt_inc;
				if (cnt_inc == len) begin
					pc_d = pc_q + PC_W'(1);
				end
			end
			SEQ_HOLD: pc_d = pc_q;
			default:  pc_d = pc_q;
		endcase
		if (last) begin
			pc_d  = '0;
			cnt_d = '0;
			pos_d = '0;
		end
	end

	// Step counter advances once per emitted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			cnt_q <= '0;
			pos_q <= '0;
		end else if (step_en) begin
			pc_q  <= pc_d;
			cnt_q <= cnt_d;
			pos_q <= pos_d;
		end
	end

endmodule

FILE: sv/sdt_datapath.sv
module sdt_datapath
	import sdt_pkg::*;
#(
	parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  op_t              wr_op,
	input  logic [5:0]       wr_index,
	input  logic [7:0]       wr_data,
	input  logic             rd_en,
	input  logic [LEN_W-1:0] rd_index,
	input  logic             step_en,
	input  seq_ctrl_t        ctrl,
	input  cfg_t             cfg,
	output logic [7:0]       byte_out
);

	localparam int AW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;

	logic [7:0]    prov_mem [MAX_NAME_LEN];
	logic [7:0]    name_mem [MAX_NAME_LEN];
	logic [7:0]    prov_rd_q;
	logic [7:0]    name_rd_q;
	logic [31:0]   crc_q;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [8:0]    sec_len;
	logic [8:0]    loop_len;
	logic [8:0]    desc_len;
	logic [8:0]    names;

	assign wr_addr = AW'({1'b0, wr_index});
	assign rd_addr = rd_index[AW-1:0];

	// Name stores; both are read at the loop index when a read is taken.
	always_ff @(posedge clk) begin
		if (wr_en && wr_op == OP_WR_PROV) begin
			prov_mem[wr_addr] <= wr_data;
		end
		if (wr_en && wr_op == OP_WR_NAME) begin
			name_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			prov_rd_q <= prov_mem[rd_addr];
			name_rd_q <= name_mem[rd_addr];
		end
	end

	// Length fields derived from the saturated name lengths.
	assign names    = 9'(cfg.plen) + 9'(cfg.nlen);
	assign sec_len  = names + 9'(SECT_FIXED + 1);
	assign loop_len = names + 9'(LOOP_FIXED);
	assign desc_len = names + 9'(DESC_FIXED);

	// Byte selection under microcode control.
	always_comb begin
		byte_out = ctrl.konst;
		unique case (ctrl.src)
			SRC_CONST:   byte_out = ctrl.konst;
			SRC_SLEN_HI: byte_out = {7'b1111_000, sec_len[8]};
			SRC_SLEN_LO: byte_out = sec_len[7:0];
			SRC_TSID_HI: byte_out = cfg.tsid[15:8];
			SRC_TSID_LO: byte_out = cfg.tsid[7:0];
			SRC_VER:     byte_out = {2'b11, cfg.version, 1'b1};
			SRC_ONID_HI: byte_out = cfg.onid[15:8];
			SRC_ONID_LO: byte_out = cfg.onid[7:0];
			SRC_SID_HI:  byte_out = cfg.sid[15:8];
			SRC_SID_LO:  byte_out = cfg.sid[7:0];
			SRC_LOOP_HI: byte_out = {cfg.run, 4'b0000, loop_len[8]};
			SRC_LOOP_LO: byte_out = loop_len[7:0];
			SRC_DLEN:    byte_out = desc_len[7:0];
			SRC_KIND:    byte_out = cfg.kind;
			SRC_PLEN:    byte_out = {1'b0, cfg.plen};
			SRC_PROV:    byte_out = prov_rd_q;
			SRC_NLEN:    byte_out = {1'b0, cfg.nlen};
			SRC_NAME:    byte_out = name_rd_q;
			SRC_CRC3:    byte_out = crc_q[31:24];
			SRC_CRC2:    byte_out = crc_q[23:16];
			SRC_CRC1:    byte_out = crc_q[15:8];
			SRC_CRC0:    byte_out = crc_q[7:0];
			default:     byte_out = ctrl.konst;
		endcase
	end

	// Section CRC, one byte per step; restarts after the final packet byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (step_en) begin
			if (ctrl.last) begin
				crc_q <= CRC_INIT;
			end else if (ctrl.crc_en) begin
				crc_q <= crc_byte(crc_q, byte_out);
			end
		end
	end

endmodule

FILE: sv/sdt_transport_packet_builder.sv
// Builds a 188-byte transport packet carrying a single-service SDT section.
// Input transactions with operation 0 or 1 write one provider-name or
// service-name byte into its store; a write whose index is beyond the
// store depth is dropped. Each input transaction with operation 2 yields
// the next packet byte on the output, with tlast on the final byte. A
// read registers the name stores and is followed by the microcoded step,
// which waits for room in the output register, selects the byte and
// updates the CRC-32/MPEG-2. The output register lets the next input
// transaction be taken while a byte waits to be collected. Name lengths
// above the store depth saturate to the depth. Configuration registers are
// at byte addresses 4*i and should only be written between packets' reads.
module sdt_transport_packet_builder
	import sdt_pkg::*;
#(
	parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [5:0] char_index, [13:6] char_byte
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] packet_byte
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t             cfg;
	seq_ctrl_t        ctrl;
	logic [LEN_W-1:0] cnt;
	logic [7:0]       byte_out;
	logic             pend_q;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic             m_tlast_q;
	logic             accept;
	logic             rd_accept;
	logic             wr_accept;
	logic             step_en;
	op_t              op;

	assign pready    = 1'b1;
	assign op        = op_t'(s_tuser);
	assign s_tready  = !pend_q;
	assign accept    = s_tvalid && s_tready;
	assign rd_accept = accept && op == OP_READ;
	assign wr_accept = accept && (op == OP_WR_PROV || op == OP_WR_NAME)
		&& ({1'b0, s_tdata[5:0]} < 7'(MAX_NAME_LEN));
	assign step_en   = pend_q && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	sdt_apb_regs #(
		.MAX_NAME_LEN(MAX_NAME_LEN)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	sdt_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.plen    (cfg.plen),
		.nlen    (cfg.nlen),
		.ctrl    (ctrl),
		.cnt     (cnt)
	);

	sdt_datapath #(
		.MAX_NAME_LEN(MAX_NAME_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_accept),
		.wr_op    (op),
		.wr_index (s_tdata[5:0]),
		.wr_data  (s_tdata[13:6]),
		.rd_en    (rd_accept),
		.rd_index (cnt),
		.step_en  (step_en),
		.ctrl     (ctrl),
		.cfg      (cfg),
		.byte_out (byte_out)
	);

	// A read transaction stays pending until its byte enters the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (rd_accept) begin
			pend_q <= 1'b1;
		end else if (step_en) begin
			pend_q <= 1'b0;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (step_en) begin
			m_tdata_q <= byte_out;
			m_tlast_q <= ctrl.last;
		end
	end

endmodule
